[hdl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define FIAC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FIAC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/fiac_pkg.sv]
// types and constants of the frame interval anomaly check
package fiac_pkg;

	localparam int NUM_REGS  = 4;
	localparam int REG_IDX_W = 2;
	localparam int ENTRY_W   = 64;
	localparam int ID_W      = 16;
	localparam int TIME_W    = 32;
	localparam int NOM_W     = 24;
	localparam int PCT_W     = 12;

	// nominal/100 as a multiply by 2^31/100 rounded up, a scaled reciprocal of 100
	localparam int DIV100_MUL_W = 25;
	localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 25'd21474837;
	localparam int DIV100_SHIFT = 31;
	localparam int DIV_PROD_W   = NOM_W + DIV100_MUL_W;
	localparam int BASE_W       = DIV_PROD_W - DIV100_SHIFT;
	localparam int BOUND_PROD_W = BASE_W + PCT_W;

	// configuration register indexes
	typedef enum logic [REG_IDX_W-1:0] {
		REG_ENTRY_0,
		REG_ENTRY_1,
		REG_ENTRY_2,
		REG_ENTRY_3
	} fiac_reg_e;

	localparam logic [ENTRY_W-1:0] ENTRY_RESET [NUM_REGS] = '{
		64'd900774901710848017,
		64'd900774901710848016,
		64'd2251854795820236864,
		64'd4503610688022773920
	};

	// layout of one entry register
	typedef struct packed {
		logic [PCT_W-1:0] high_pct;
		logic [PCT_W-1:0] low_pct;
		logic [NOM_W-1:0] nominal;
		logic [ID_W-1:0]  id;
	} fiac_entry_t;

	// per-source state word held in memory
	typedef struct packed {
		logic [TIME_W-1:0] count;
		logic [TIME_W-1:0] last;
	} fiac_word_t;

	// pipeline stage control
	typedef struct packed {
		logic vld;
		logic hit;
	} fiac_ctl_t;

	// result of one item
	typedef struct packed {
		logic              anomalous;
		logic              monitored;
		logic [TIME_W-1:0] violations;
	} fiac_res_t;

endpackage

[hdl/frame_interval_anomaly_check.sv]
// top level of the frame interval anomaly check
//
// Input channel (in_valid/in_ready) carries one received frame per item:
// src_id and the arrival time now_us in microseconds. Output channel
// (out_valid/out_ready) returns one result item per frame: anomalous,
// monitored and the matched entry's violation count.
// Four entry registers are written through cfg_we/cfg_idx/cfg_wdata; the user
// must write them only while no item is in flight (the block does not enforce
// it); each packs id, nominal interval, low and high percent.
// A result passes through stages s1, s2 and s3 and then the output register.
// Throughput: one item per cycle while the receiver does not stall; the state
// memory is read one stage ahead of its single write port, and a one-entry
// forward covers back-to-back frames of the same source.
// Reset clears the arrival times and counters at once (written marks per
// entry) and loads the default entries; no clearing pass is needed.
// When the receiver stalls, the whole pipeline holds and in_ready drops in
// the same cycle; the result stays in the output register until taken.
module frame_interval_anomaly_check #(
	parameter int ENTRIES = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fiac_pkg::REG_IDX_W-1:0]  cfg_idx,
	input  logic [fiac_pkg::ENTRY_W-1:0]    cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [fiac_pkg::ID_W-1:0]       src_id,
	input  logic [fiac_pkg::TIME_W-1:0]     now_us,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            anomalous,
	output logic                            monitored,
	output logic [fiac_pkg::TIME_W-1:0]     violations
);
	import fiac_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic              en;
	logic              hit;
	logic [IDX_W-1:0]  idx;
	fiac_entry_t       sel;
	logic [IDX_W-1:0]  idx_s2, idx_s3;
	fiac_ctl_t         ctl_s3;
	logic [TIME_W-1:0] now_s3, lo_s3, hi_s3;
	fiac_res_t         res;
	logic              out_valid_q;
	fiac_res_t         res_q;

	// pipeline advances whenever the output register is free or drained
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	fiac_match #(
		.ENTRIES (ENTRIES),
		.IDX_W   (IDX_W)
	) u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.src_id    (src_id),
		.hit       (hit),
		.idx       (idx),
		.sel       (sel)
	);

	fiac_window #(
		.IDX_W (IDX_W)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (in_valid),
		.hit    (hit),
		.idx    (idx),
		.now_us (now_us),
		.sel    (sel),
		.idx_s2 (idx_s2),
		.ctl_s3 (ctl_s3),
		.idx_s3 (idx_s3),
		.now_s3 (now_s3),
		.lo_s3  (lo_s3),
		.hi_s3  (hi_s3)
	);

	fiac_state #(
		.ENTRIES (ENTRIES),
		.IDX_W   (IDX_W)
	) u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.rd_idx (idx_s2),
		.ctl_s3 (ctl_s3),
		.idx_s3 (idx_s3),
		.now_s3 (now_s3),
		.lo_s3  (lo_s3),
		.hi_s3  (hi_s3),
		.res    (res)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctl_s3.vld;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign anomalous  = res_q.anomalous;
	assign monitored  = res_q.monitored;
	assign violations = res_q.violations;

endmodule

[hdl/fiac_match.sv]
// entry registers and lowest-index source id match
module fiac_match #(
	parameter int ENTRIES = 4,
	parameter int IDX_W   = 2
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fiac_pkg::REG_IDX_W-1:0]  cfg_idx,
	input  logic [fiac_pkg::ENTRY_W-1:0]    cfg_wdata,
	input  logic [fiac_pkg::ID_W-1:0]       src_id,
	output logic                            hit,
	output logic [IDX_W-1:0]                idx,
	output fiac_pkg::fiac_entry_t           sel
);
	import fiac_pkg::*;

	fiac_entry_t entry_w [ENTRIES];

	// configured entries; slots past the register list stay zero
	for (genvar i = 0; i < ENTRIES; i++) begin : g_entry
		if (i < NUM_REGS) begin : g_reg
			logic [ENTRY_W-1:0] entry_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					entry_q <= ENTRY_RESET[i];
				end else if (cfg_we && (cfg_idx == REG_IDX_W'(i))) begin
					entry_q <= cfg_wdata;
				end
			end

			assign entry_w[i] = fiac_entry_t'(entry_q);
		end else begin : g_zero
			assign entry_w[i] = '0;
		end
	end

	// priority match, lowest index wins
	always_comb begin
		hit = 1'b0;
		idx = '0;
		sel = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (entry_w[i].id == src_id) begin
				hit = 1'b1;
				idx = IDX_W'(i);
				sel = entry_w[i];
			end
		end
	end

endmodule

[hdl/fiac_window.sv]
// item pipeline that works out the accepted interval window
module fiac_window #(
	parameter int IDX_W = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_vld,
	input  logic                           hit,
	input  logic [IDX_W-1:0]               idx,
	input  logic [fiac_pkg::TIME_W-1:0]    now_us,
	input  fiac_pkg::fiac_entry_t          sel,
	output logic [IDX_W-1:0]               idx_s2,
	output fiac_pkg::fiac_ctl_t            ctl_s3,
	output logic [IDX_W-1:0]               idx_s3,
	output logic [fiac_pkg::TIME_W-1:0]    now_s3,
	output logic [fiac_pkg::TIME_W-1:0]    lo_s3,
	output logic [fiac_pkg::TIME_W-1:0]    hi_s3
);
	import fiac_pkg::*;

	fiac_ctl_t            ctl_s1, ctl_s2;
	logic [IDX_W-1:0]     idx_s1;
	logic [TIME_W-1:0]    now_s1, now_s2;
	logic [NOM_W-1:0]     nominal_s1;
	logic [PCT_W-1:0]     lo_pct_s1, hi_pct_s1, lo_pct_s2, hi_pct_s2;
	logic [BASE_W-1:0]    base_s2;
	logic [DIV_PROD_W-1:0]   div_prod;
	logic [BOUND_PROD_W-1:0] lo_prod, hi_prod;

	// truncating divide by 100
	assign div_prod = DIV_PROD_W'(nominal_s1) * DIV_PROD_W'(DIV100_MUL);

	// window bounds, always within 32 bits
	assign lo_prod = BOUND_PROD_W'(base_s2) * BOUND_PROD_W'(lo_pct_s2);
	assign hi_prod = BOUND_PROD_W'(base_s2) * BOUND_PROD_W'(hi_pct_s2);

	// stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s1 <= '{vld: in_vld, hit: hit};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1     <= idx;
			now_s1     <= now_us;
			nominal_s1 <= sel.nominal;
			lo_pct_s1  <= sel.low_pct;
			hi_pct_s1  <= sel.high_pct;

			idx_s2    <= idx_s1;
			now_s2    <= now_s1;
			base_s2   <= div_prod[DIV100_SHIFT +: BASE_W];
			lo_pct_s2 <= lo_pct_s1;
			hi_pct_s2 <= hi_pct_s1;

			idx_s3 <= idx_s2;
			now_s3 <= now_s2;
			lo_s3  <= TIME_W'(lo_prod);
			hi_s3  <= TIME_W'(hi_prod);
		end
	end

endmodule

[hdl/fiac_state.sv]
// per-source state memory with read-modify-write and forwarding
module fiac_state #(
	parameter int ENTRIES = 4,
	parameter int IDX_W   = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic [IDX_W-1:0]               rd_idx,
	input  fiac_pkg::fiac_ctl_t            ctl_s3,
	input  logic [IDX_W-1:0]               idx_s3,
	input  logic [fiac_pkg::TIME_W-1:0]    now_s3,
	input  logic [fiac_pkg::TIME_W-1:0]    lo_s3,
	input  logic [fiac_pkg::TIME_W-1:0]    hi_s3,
	output fiac_pkg::fiac_res_t            res
);
	import fiac_pkg::*;

	fiac_word_t        mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	fiac_word_t        rd_word_s3;
	logic              rd_vld_s3;
	logic              fwd_vld_q;
	logic [IDX_W-1:0]  fwd_idx_q;
	fiac_word_t        fwd_word_q;
	fiac_word_t        cur;
	fiac_word_t        wr_word;
	logic              wr_en;
	logic              outside;
	logic [TIME_W-1:0] dt;
	logic [TIME_W-1:0] new_cnt;

	// current state: last write wins over the stale read, unwritten reads as zero
	always_comb begin
		if (fwd_vld_q && (fwd_idx_q == idx_s3)) begin
			cur = fwd_word_q;
		end else if (rd_vld_s3) begin
			cur = rd_word_s3;
		end else begin
			cur = '0;
		end
	end

	// interval check against the window
	assign dt      = now_s3 - cur.last;
	assign outside = (cur.last != '0) && ((dt < lo_s3) || (dt > hi_s3));
	assign new_cnt = cur.count + TIME_W'(outside);
	assign wr_en   = en && ctl_s3.vld && ctl_s3.hit;
	assign wr_word = '{count: new_cnt, last: now_s3};

	assign res.anomalous  = ctl_s3.hit && outside;
	assign res.monitored  = ctl_s3.hit;
	assign res.violations = ctl_s3.hit ? new_cnt : '0;

	// state memory, read before write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx_s3] <= wr_word;
		end
		if (en) begin
			rd_word_s3 <= mem[rd_idx];
		end
	end

	// written marks and read valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_vld_s3 <= 1'b0;
			fwd_vld_q <= 1'b0;
		end else if (en) begin
			rd_vld_s3 <= valid_q[rd_idx];
			fwd_vld_q <= wr_en;
			if (wr_en) begin
				valid_q[idx_s3] <= 1'b1;
			end
		end
	end

	// forwarding copy of the last write
	always_ff @(posedge clk) begin
		if (en) begin
			fwd_idx_q  <= idx_s3;
			fwd_word_q <= wr_word;
		end
	end

endmodule

[hdl/fiac_checker.sv]
// port-level checks of the frame interval anomaly check and its bind
`include "assert_macros.svh"

module fiac_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        anomalous,
	input logic        monitored,
	input logic [31:0] violations
);

	// a stalled result holds
	`FIAC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(violations) && $stable(anomalous) && $stable(monitored), "stalled result changed")

	// input side is ready exactly when the output register can move
	`FIAC_ASSERT_NOW(a_ready_link, 1'b1, in_ready == (!out_valid || out_ready), "in_ready does not follow output stall")

	// an anomaly only comes from a matched entry
	`FIAC_ASSERT_NOW(a_anom_mon, out_valid && anomalous, monitored, "anomaly on an unmatched item")

	// unmatched items report a zero count
	`FIAC_ASSERT_NOW(a_unmatched_zero, out_valid && !monitored, violations == 32'd0, "count on an unmatched item")

endmodule

bind frame_interval_anomaly_check fiac_checker u_fiac_checker (.*);
